FILE: rtl/acr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acr_pkg
// Shared types for the box collision resolve pipeline.
// ----------------------------------------------------------------------------
package acr_pkg;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_POS_X = 3'd1,
        DIR_NEG_X = 3'd2,
        DIR_POS_Y = 3'd3,
        DIR_NEG_Y = 3'd4
    } dir_t;

    typedef struct packed {
        logic s1;
        logic s2;
    } acr_adv_t;

    typedef struct packed {
        logic coll;
        logic from_left;
        logic from_top;
        logic is_static;
    } acr_flags_t;

endpackage
`default_nettype wire

FILE: rtl/aabb_collision_resolve_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_collision_resolve_top
// 2D box collision test with minimum translation push-out, fixed point.
//
// channel  dir  tdata                                    tuser
// s_*      in   a_left a_top a_right a_bottom            b_is_static
//               b_left b_top b_right b_bottom
// m_*      out  normal_dir x_depth y_depth               colliding
//               a_shift_x a_shift_y b_shift_x b_shift_y
//
// one beat per cycle while the output side is not stalled
// stages: extents, axis minimum, push select, shift form and output register
// each stage holds its beat while the next one is full and stalled
// reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module aabb_collision_resolve_top #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
    input  wire logic [8*COORD_WIDTH-1:0]      s_tdata,
    // b_is_static
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // normal_dir, x_depth, y_depth, a_shift_x, a_shift_y, b_shift_x,
    // b_shift_y, zero pad
    output logic [((6*COORD_WIDTH+7+7)/8)*8-1:0] m_tdata,
    // colliding
    output logic                               m_tuser
);
    import acr_pkg::*;

    localparam int CW       = COORD_WIDTH;
    localparam int OUT_BITS = 6*CW + 7;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int PAD_W    = OUT_W - OUT_BITS;

    logic signed [CW-1:0] a_left, a_top, a_right, a_bottom;
    logic signed [CW-1:0] b_left, b_top, b_right, b_bottom;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    acr_adv_t adv;

    logic [CW-1:0] xo2, yo2;
    acr_flags_t    f2;

    logic [CW-1:0] amt_reg, amt_next, push3;
    logic [CW-1:0] xo3_reg, yo3_reg;
    logic          x_axis_next, x_axis_reg, a_pos_reg, coll3_reg, static3_reg;
    dir_t          dir3_reg, dir3_next;

    logic signed [CW:0] a_amt, b_amt;
    logic               coll_reg;
    dir_t               dir_reg, dir_next;
    logic [CW-1:0]      xo_reg, xo_next, yo_reg, yo_next;
    logic signed [CW:0] asx_reg, asx_next, asy_reg, asy_next;
    logic signed [CW:0] bsx_reg, bsx_next, bsy_reg, bsy_next;

    assign a_left   = s_tdata[0*CW +: CW];
    assign a_top    = s_tdata[1*CW +: CW];
    assign a_right  = s_tdata[2*CW +: CW];
    assign a_bottom = s_tdata[3*CW +: CW];
    assign b_left   = s_tdata[4*CW +: CW];
    assign b_top    = s_tdata[5*CW +: CW];
    assign b_right  = s_tdata[6*CW +: CW];
    assign b_bottom = s_tdata[7*CW +: CW];

    // stage advance, a stage moves when it is empty or its successor moves
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign adv.s1   = rdy1;
    assign adv.s2   = rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    acr_overlap #(
        .CW (CW)
    ) u_overlap (
        .clk         (clk),
        .adv         (adv),
        .a_left      (a_left),
        .a_top       (a_top),
        .a_right     (a_right),
        .a_bottom    (a_bottom),
        .b_left      (b_left),
        .b_top       (b_top),
        .b_right     (b_right),
        .b_bottom    (b_bottom),
        .b_is_static (s_tuser),
        .x_depth     (xo2),
        .y_depth     (yo2),
        .flags       (f2)
    );

    // stage 3: push axis and magnitude
    always_comb
    begin
        x_axis_next = xo2 < yo2;
        push3       = x_axis_next ? xo2 : yo2;
        amt_next    = f2.is_static ? push3 : (push3 >> 1);
        if (x_axis_next)
            dir3_next = f2.from_left ? DIR_NEG_X : DIR_POS_X;
        else
            dir3_next = f2.from_top ? DIR_NEG_Y : DIR_POS_Y;
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            amt_reg     <= amt_next;
            x_axis_reg  <= x_axis_next;
            a_pos_reg   <= x_axis_next ? f2.from_left : f2.from_top;
            coll3_reg   <= f2.coll;
            static3_reg <= f2.is_static;
            dir3_reg    <= dir3_next;
            xo3_reg     <= xo2;
            yo3_reg     <= yo2;
        end
    end

    // stage 4: signed shifts, zero when apart
    always_comb
    begin
        a_amt    = a_pos_reg ? $signed({1'b0, amt_reg}) : -$signed({1'b0, amt_reg});
        b_amt    = static3_reg ? '0 : -a_amt;
        dir_next = coll3_reg ? dir3_reg : DIR_NONE;
        xo_next  = coll3_reg ? xo3_reg : '0;
        yo_next  = coll3_reg ? yo3_reg : '0;
        asx_next = (coll3_reg && x_axis_reg)  ? a_amt : '0;
        bsx_next = (coll3_reg && x_axis_reg)  ? b_amt : '0;
        asy_next = (coll3_reg && !x_axis_reg) ? a_amt : '0;
        bsy_next = (coll3_reg && !x_axis_reg) ? b_amt : '0;
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            coll_reg <= coll3_reg;
            dir_reg  <= dir_next;
            xo_reg   <= xo_next;
            yo_reg   <= yo_next;
            asx_reg  <= asx_next;
            asy_reg  <= asy_next;
            bsx_reg  <= bsx_next;
            bsy_reg  <= bsy_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tuser  = coll_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, bsy_reg, bsx_reg, asy_reg, asx_reg,
                       yo_reg, xo_reg, dir_reg};

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> s_tready)
        else $error("input not ready with empty first stage");

    a_apart_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !coll_reg |-> dir_reg == DIR_NONE && xo_reg == '0 && yo_reg == '0
            && asx_reg == '0 && asy_reg == '0 && bsx_reg == '0 && bsy_reg == '0)
        else $error("nonzero result for separated boxes");

    a_hit_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && coll_reg |-> xo_reg != '0 && yo_reg != '0 && dir_reg != DIR_NONE)
        else $error("collision with empty overlap");

    a_x_push_axis: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && (dir_reg == DIR_POS_X || dir_reg == DIR_NEG_X)
            |-> asy_reg == '0 && bsy_reg == '0)
        else $error("y shift on an x push");

    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && rdy4 |=> v4_reg)
        else $error("beat lost between push and output stages");

endmodule
`default_nettype wire

FILE: rtl/acr_overlap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acr_overlap
// First two pipeline stages: intersect extents, then per-axis overlap.
// ----------------------------------------------------------------------------
module acr_overlap #(
    parameter int CW = 32
) (
    input  wire logic                  clk,
    input  wire acr_pkg::acr_adv_t     adv,
    input  wire logic signed [CW-1:0]  a_left,
    input  wire logic signed [CW-1:0]  a_top,
    input  wire logic signed [CW-1:0]  a_right,
    input  wire logic signed [CW-1:0]  a_bottom,
    input  wire logic signed [CW-1:0]  b_left,
    input  wire logic signed [CW-1:0]  b_top,
    input  wire logic signed [CW-1:0]  b_right,
    input  wire logic signed [CW-1:0]  b_bottom,
    input  wire logic                  b_is_static,
    output logic [CW-1:0]              x_depth,
    output logic [CW-1:0]              y_depth,
    output acr_pkg::acr_flags_t        flags
);
    import acr_pkg::*;

    logic signed [CW:0] ext_l_reg, ext_r_reg, ext_t_reg, ext_b_reg;
    logic signed [CW:0] ext_l_next, ext_r_next, ext_t_next, ext_b_next;
    logic               static_reg;

    logic [CW-1:0]      xo_reg, xo_next, yo_reg, yo_next;
    acr_flags_t         flags_reg, flags_next;

    // stage 1: extents, one bit wider than the coordinates
    always_comb
    begin
        ext_l_next = {b_right[CW-1], b_right} - {a_left[CW-1], a_left};
        ext_r_next = {a_right[CW-1], a_right} - {b_left[CW-1], b_left};
        ext_t_next = {b_bottom[CW-1], b_bottom} - {a_top[CW-1], a_top};
        ext_b_next = {a_bottom[CW-1], a_bottom} - {b_top[CW-1], b_top};
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            ext_l_reg  <= ext_l_next;
            ext_r_reg  <= ext_r_next;
            ext_t_reg  <= ext_t_next;
            ext_b_reg  <= ext_b_next;
            static_reg <= b_is_static;
        end
    end

    // stage 2: positivity and smaller extent per axis, ties to right and bottom
    always_comb
    begin
        flags_next.coll      = !ext_l_reg[CW] && (|ext_l_reg[CW-1:0])
                            && !ext_r_reg[CW] && (|ext_r_reg[CW-1:0])
                            && !ext_t_reg[CW] && (|ext_t_reg[CW-1:0])
                            && !ext_b_reg[CW] && (|ext_b_reg[CW-1:0]);
        flags_next.from_left = ext_l_reg < ext_r_reg;
        flags_next.from_top  = ext_t_reg < ext_b_reg;
        flags_next.is_static = static_reg;
        xo_next = flags_next.from_left ? ext_l_reg[CW-1:0] : ext_r_reg[CW-1:0];
        yo_next = flags_next.from_top  ? ext_t_reg[CW-1:0] : ext_b_reg[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            xo_reg    <= xo_next;
            yo_reg    <= yo_next;
            flags_reg <= flags_next;
        end
    end

    assign x_depth = xo_reg;
    assign y_depth = yo_reg;
    assign flags   = flags_reg;

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for aabb_collision_resolve_top. Box pairs go in as
// stream beats in random bursts, a local push-out calculator predicts each
// output beat, and the monitor compares every field while the output side
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
    import acr_pkg::*;

    localparam int CW        = 32;
    localparam int OUT_W     = ((6 * CW + 7 + 7) / 8) * 8;
    localparam int XO_LSB    = 3;
    localparam int YO_LSB    = 3 + CW;
    localparam int SH_LSB    = 3 + 2 * CW;
    localparam int SH_W      = CW + 1;
    localparam int N_RANDOM  = 2000;
    localparam int IDLE_MAX  = 4000;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        int a_left;
        int a_top;
        int a_right;
        int a_bottom;
        int b_left;
        int b_top;
        int b_right;
        int b_bottom;
        bit b_is_static;
    } box_pair_t;

    typedef struct {
        logic              colliding;
        dir_t              normal_dir;
        logic [CW-1:0]     x_depth;
        logic [CW-1:0]     y_depth;
        logic [SH_W-1:0]   a_shift_x;
        logic [SH_W-1:0]   a_shift_y;
        logic [SH_W-1:0]   b_shift_x;
        logic [SH_W-1:0]   b_shift_y;
    } push_out_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [8*CW-1:0]    s_tdata = '0;    // a_left .. a_bottom, b_left .. b_bottom
    logic               s_tuser = 1'b0;  // b_is_static
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;         // normal_dir, overlaps, shifts, pad
    logic               m_tuser;         // colliding

    box_pair_t pair_q[$];
    push_out_t push_q[$];

    int fail_cnt   = 0;
    int beat_no    = 0;
    int burst_left = 8;
    int gap_left   = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int idle_cnt   = 0;

    aabb_collision_resolve_top #(
        .COORD_WIDTH(CW)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic push_out_t resolve_pair(box_pair_t p);
        push_out_t r;
        longint    ext_l;
        longint    ext_r;
        longint    ext_t;
        longint    ext_b;
        longint    xo;
        longint    yo;
        longint    push;
        longint    amt;
        longint    a_amt;
        longint    b_amt;
        bit        from_left;
        bit        from_top;
        bit        x_axis;
        bit        a_pos;
        ext_l = longint'(p.b_right) - longint'(p.a_left);
        ext_r = longint'(p.a_right) - longint'(p.b_left);
        ext_t = longint'(p.b_bottom) - longint'(p.a_top);
        ext_b = longint'(p.a_bottom) - longint'(p.b_top);
        r.colliding  = 1'b0;
        r.normal_dir = DIR_NONE;
        r.x_depth    = '0;
        r.y_depth    = '0;
        r.a_shift_x  = '0;
        r.a_shift_y  = '0;
        r.b_shift_x  = '0;
        r.b_shift_y  = '0;
        if (ext_l <= 0 || ext_r <= 0 || ext_t <= 0 || ext_b <= 0)
            return r;
        from_left = ext_l < ext_r;
        from_top  = ext_t < ext_b;
        xo        = from_left ? ext_l : ext_r;
        yo        = from_top ? ext_t : ext_b;
        x_axis    = xo < yo;
        push      = x_axis ? xo : yo;
        amt       = p.b_is_static ? push : (push >>> 1);
        a_pos     = x_axis ? from_left : from_top;
        a_amt     = a_pos ? amt : -amt;
        b_amt     = p.b_is_static ? 0 : -a_amt;
        r.colliding = 1'b1;
        if (x_axis)
        begin
            r.normal_dir = from_left ? DIR_NEG_X : DIR_POS_X;
            r.a_shift_x  = a_amt[SH_W-1:0];
            r.b_shift_x  = b_amt[SH_W-1:0];
        end
        else
        begin
            r.normal_dir = from_top ? DIR_NEG_Y : DIR_POS_Y;
            r.a_shift_y  = a_amt[SH_W-1:0];
            r.b_shift_y  = b_amt[SH_W-1:0];
        end
        r.x_depth = xo[CW-1:0];
        r.y_depth = yo[CW-1:0];
        return r;
    endfunction

    function automatic longint random_extent();
        int k;
        k = $urandom_range(0, 28);
        if ($urandom_range(0, 3) == 0)
            return longint'($urandom_range(1, 4));
        return 1 + longint'($urandom & ((32'd1 << k) - 1));
    endfunction

    function automatic box_pair_t random_pair();
        box_pair_t p;
        longint    cx;
        longint    cy;
        longint    aw;
        longint    ah;
        longint    bw;
        longint    bh;
        longint    bx;
        longint    by;
        p.b_is_static = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
        begin
            p.a_left   = $urandom;
            p.a_top    = $urandom;
            p.a_right  = $urandom;
            p.a_bottom = $urandom;
            p.b_left   = $urandom;
            p.b_top    = $urandom;
            p.b_right  = $urandom;
            p.b_bottom = $urandom;
            return p;
        end
        cx = longint'(int'($urandom)) >>> 1;
        cy = longint'(int'($urandom)) >>> 1;
        aw = random_extent();
        ah = random_extent();
        bw = random_extent();
        bh = random_extent();
        // offsets span touching on both sides, so near misses show up too
        bx = cx + longint'($urandom_range(0, 32'(aw + bw))) - bw;
        by = cy + longint'($urandom_range(0, 32'(ah + bh))) - bh;
        p.a_left   = int'(cx);
        p.a_top    = int'(cy);
        p.a_right  = int'(cx + aw);
        p.a_bottom = int'(cy + ah);
        p.b_left   = int'(bx);
        p.b_top    = int'(by);
        p.b_right  = int'(bx + bw);
        p.b_bottom = int'(by + bh);
        return p;
    endfunction

    task automatic add_pair(input int al, input int at, input int ar, input int ab,
                            input int bl, input int bt, input int br, input int bb,
                            input bit st);
        box_pair_t p;
        p.a_left      = al;
        p.a_top       = at;
        p.a_right     = ar;
        p.a_bottom    = ab;
        p.b_left      = bl;
        p.b_top       = bt;
        p.b_right     = br;
        p.b_bottom    = bb;
        p.b_is_static = st;
        pair_q.push_back(p);
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_cnt++;
        if (fail_cnt <= MAX_SHOWN)
            $display("beat %0d %s mismatch: expected %h actual %h", beat_no, field,
                     want, got);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        box_pair_t p;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                push_q.push_back(resolve_pair(pair_q.pop_front()));
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pair_q.size() > 0)
            begin
                p = pair_q[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {p.b_bottom, p.b_right, p.b_top, p.b_left,
                             p.a_bottom, p.a_right, p.a_top, p.a_left};
                s_tuser  <= p.b_is_static;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches between phases of different density
    always @(posedge clk)
    begin
        if (rx_left <= 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 200);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_left % 4) == 0;
            default: m_tready <= $urandom_range(0, 3) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        push_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (push_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_SHOWN)
                    $display("beat %0d arrived with nothing expected", beat_no);
            end
            else
            begin
                want = push_q.pop_front();
                if (m_tuser !== want.colliding)
                    note_mismatch("colliding", 64'(want.colliding), 64'(m_tuser));
                if (m_tdata[2:0] !== want.normal_dir)
                    note_mismatch("normal_dir", 64'(want.normal_dir), 64'(m_tdata[2:0]));
                if (m_tdata[XO_LSB +: CW] !== want.x_depth)
                    note_mismatch("x_depth", 64'(want.x_depth),
                                  64'(m_tdata[XO_LSB +: CW]));
                if (m_tdata[YO_LSB +: CW] !== want.y_depth)
                    note_mismatch("y_depth", 64'(want.y_depth),
                                  64'(m_tdata[YO_LSB +: CW]));
                if (m_tdata[SH_LSB +: SH_W] !== want.a_shift_x)
                    note_mismatch("a_shift_x", 64'(want.a_shift_x),
                                  64'(m_tdata[SH_LSB +: SH_W]));
                if (m_tdata[SH_LSB + SH_W +: SH_W] !== want.a_shift_y)
                    note_mismatch("a_shift_y", 64'(want.a_shift_y),
                                  64'(m_tdata[SH_LSB + SH_W +: SH_W]));
                if (m_tdata[SH_LSB + 2 * SH_W +: SH_W] !== want.b_shift_x)
                    note_mismatch("b_shift_x", 64'(want.b_shift_x),
                                  64'(m_tdata[SH_LSB + 2 * SH_W +: SH_W]));
                if (m_tdata[SH_LSB + 3 * SH_W +: SH_W] !== want.b_shift_y)
                    note_mismatch("b_shift_y", 64'(want.b_shift_y),
                                  64'(m_tdata[SH_LSB + 3 * SH_W +: SH_W]));
            end
            beat_no++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt == IDLE_MAX)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        // apart, touching in x, touching in y
        add_pair(0, 0, 10, 10, 20, 20, 30, 30, 1'b0);
        add_pair(0, 0, 10, 10, 10, 0, 20, 10, 1'b0);
        add_pair(0, 0, 10, 10, 0, 10, 10, 20, 1'b1);
        // one push per normal, moving and static partner
        add_pair(0, 0, 10, 10, -8, 0, 2, 10, 1'b0);
        add_pair(0, 0, 10, 10, -8, 0, 2, 10, 1'b1);
        add_pair(0, 0, 10, 10, 8, 0, 18, 10, 1'b0);
        add_pair(0, 0, 10, 10, 8, 0, 18, 10, 1'b1);
        add_pair(0, 0, 10, 10, 0, -7, 10, 3, 1'b0);
        add_pair(0, 0, 10, 10, 0, -7, 10, 3, 1'b1);
        add_pair(0, 0, 10, 10, 0, 7, 10, 17, 1'b0);
        add_pair(0, 0, 10, 10, 0, 7, 10, 17, 1'b1);
        // identical boxes and equal overlaps on both axes
        add_pair(0, 0, 10, 10, 0, 0, 10, 10, 1'b0);
        add_pair(0, 0, 10, 10, 7, 7, 17, 17, 1'b0);
        // push of one, half rounds to zero
        add_pair(0, 0, 10, 10, 9, 0, 19, 10, 1'b0);
        // full coordinate range
        add_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        add_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        add_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 0, 0, 32'h0001_0000, 32'h0001_8000, 1'b0);
        add_pair(32'h7fff_fffe, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001,
                 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        // inverted boxes, one colliding and one not
        add_pair(10, 10, 0, 0, -100, -100, 100, 100, 1'b0);
        add_pair(10, 10, 0, 0, 20, 20, 30, 30, 1'b1);
        // all-ones coordinates, fractional values
        add_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1);
        add_pair(32'hffff_8000, 32'hffff_0000, 32'h0000_8000, 32'h0001_0000,
                 32'hffff_c000, 0, 32'h0000_4000, 32'h0002_0000, 1'b0);
        for (i = 0; i < N_RANDOM; i++)
            pair_q.push_back(random_pair());
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (pair_q.size() != 0 || push_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: files.f
rtl/acr_pkg.sv
rtl/acr_overlap.sv
rtl/aabb_collision_resolve_top.sv
dv/tb.sv
